// ----- sv/ppg_hbd_pkg.sv -----
// Shared widths, constants and register codes for the PPG heart-beat detector.
package ppg_hbd_pkg;

    localparam int SAMPLE_W = 18;
    localparam int TIME_W   = 32;
    localparam int WEIGHT_W = 16;
    localparam int IVL_W    = 16;
    localparam int RATE_W   = 16;
    localparam int FRAC_W   = 16;
    localparam int BASE_W   = SAMPLE_W + FRAC_W;
    localparam int DIFF_W   = BASE_W + 1;
    localparam int ACC_W    = DIFF_W + 1;
    localparam int DIV_N_W  = 24;
    localparam int DIV_D_W  = 16;

    localparam logic [DIV_N_W-1:0] RATE_NUMERATOR = 24'd15360000;

    localparam int HISTORY_DEPTH_DEF = 8;

    localparam int ADDR_W   = 4;
    localparam int APB_W    = 32;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 40;

    localparam logic [1:0] REG_NO_FINGER = 2'd0;
    localparam logic [1:0] REG_WEIGHT    = 2'd1;
    localparam logic [1:0] REG_MIN_IVL   = 2'd2;
    localparam logic [1:0] REG_MAX_IVL   = 2'd3;

    localparam logic [SAMPLE_W-1:0] NO_FINGER_RST = 18'd50000;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST    = 16'd1311;
    localparam logic [IVL_W-1:0]    MIN_IVL_RST   = 16'd270;
    localparam logic [IVL_W-1:0]    MAX_IVL_RST   = 16'd1500;

endpackage

// ----- sv/ppg_hbd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ppg_hbd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/ppg_hbd_mac.sv -----
// Bit-serial signed-by-unsigned multiplier giving floor(weight * diff / 2^16).
module ppg_hbd_mac import ppg_hbd_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [DIFF_W-1:0] diff,
    input  logic [WEIGHT_W-1:0]      weight,
    output logic                     done,
    output logic signed [DIFF_W-1:0] product
);

    localparam int CNT_W = $clog2(WEIGHT_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WEIGHT_W - 1);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [WEIGHT_W-1:0]      wsr_reg, wsr_next;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  addend;
    logic signed [ACC_W-1:0]  acc_sum;

    always_comb begin
        addend     = wsr_reg[0] ? ACC_W'(diff_reg) : '0;
        acc_sum    = acc_reg + addend;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        wsr_next   = wsr_reg;
        diff_next  = diff_reg;
        acc_next   = acc_reg;
        if (start) begin
            busy_next  = 1'b1;
            count_next = '0;
            wsr_next   = weight;
            diff_next  = diff;
            acc_next   = '0;
        end else if (busy_reg) begin
            acc_next   = acc_sum >>> 1;
            wsr_next   = wsr_reg >> 1;
            count_next = count_reg + CNT_W'(1);
            if (count_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        count_reg <= count_next;
        wsr_reg   <= wsr_next;
        diff_reg  <= diff_next;
        acc_reg   <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg[DIFF_W-1:0];

endmodule

// ----- sv/ppg_hbd_div.sv -----
// Restoring divider producing one quotient bit per cycle.
module ppg_hbd_div import ppg_hbd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic               done,
    output logic [DIV_N_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_N_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_N_W - 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [DIV_N_W-1:0] quo_reg, quo_next;
    logic [DIV_D_W-1:0] rem_reg, rem_next;
    logic [DIV_D_W-1:0] dvs_reg, dvs_next;
    logic [DIV_D_W:0]   shifted;
    logic [DIV_D_W:0]   trial;
    logic               fits;

    always_comb begin
        shifted    = {rem_reg, quo_reg[DIV_N_W-1]};
        trial      = shifted - {1'b0, dvs_reg};
        fits       = shifted >= {1'b0, dvs_reg};
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        if (start) begin
            busy_next  = 1'b1;
            count_next = '0;
            quo_next   = dividend;
            rem_next   = '0;
            dvs_next   = divisor;
        end else if (busy_reg) begin
            rem_next   = fits ? trial[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
            quo_next   = {quo_reg[DIV_N_W-2:0], fits};
            count_next = count_reg + CNT_W'(1);
            if (count_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        count_reg <= count_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- sv/ppg_hbd_ring.sv -----
// Rate history: ring of recent beat rates with fill count and running sum.
module ppg_hbd_ring import ppg_hbd_pkg::*; #(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int CNT_W         = $clog2(HISTORY_DEPTH + 1),
    parameter int SUM_W         = RATE_W + CNT_W
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              store,
    input  logic [RATE_W-1:0] rate,
    output logic [SUM_W-1:0]  sum_new,
    output logic [CNT_W-1:0]  fill_new
);

    localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(HISTORY_DEPTH);

    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [RATE_W-1:0] ram_rdata;
    logic [RATE_W-1:0] old_rate;

    ppg_hbd_ram #(
        .WIDTH (RATE_W),
        .DEPTH (HISTORY_DEPTH),
        .AW    (SLOT_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (store),
        .waddr (slot_reg),
        .wdata (rate),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // unwritten slots read as zero until the ring has wrapped once
    always_comb begin
        old_rate  = (fill_reg == FULL_CNT) ? ram_rdata : '0;
        sum_new   = sum_reg - SUM_W'(old_rate) + SUM_W'(rate);
        fill_new  = (fill_reg == FULL_CNT) ? fill_reg : fill_reg + CNT_W'(1);
        slot_next = slot_reg;
        fill_next = fill_reg;
        sum_next  = sum_reg;
        if (store) begin
            slot_next = (slot_reg == LAST_SLOT) ? '0 : slot_reg + SLOT_W'(1);
            fill_next = fill_new;
            sum_next  = sum_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
            fill_reg <= '0;
            sum_reg  <= '0;
        end else begin
            slot_reg <= slot_next;
            fill_reg <= fill_next;
            sum_reg  <= sum_next;
        end
    end

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FULL_CNT)
        else $error("ring fill count beyond depth");

    a_slot_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= LAST_SLOT)
        else $error("ring slot beyond depth");

    a_store_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (store && fill_reg != FULL_CNT) |=> fill_reg == $past(fill_reg) + CNT_W'(1))
        else $error("ring fill count did not advance on store");

endmodule

// ----- sv/ppg_heart_beat_detector.sv -----
// PPG heart-beat detector top level: sample intake, baseline, beat sequencing, APB registers.
// One sample transaction in, one result transaction out. A sample below the no-finger level
// goes from its check straight to the result; a sample that is blended into the baseline runs
// the 16-step serial multiplier for the baseline blend; a sample that yields an accepted beat
// adds two 24-step passes of the shared restoring divider (rate, then mean). A new sample
// is taken only when the previous one has finished its work; a finished result may still be
// waiting on the output register while the next sample is taken. The rate history ring
// needs no clearing pass after reset.
module ppg_heart_beat_detector import ppg_hbd_pkg::*; #(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // ir_sample[17:0], timestamp_ms[49:18], zero pad
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // beat_detected[0], finger_present[1],
                                          // current_bpm[17:2], average_bpm[33:18], zero pad
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [APB_W-1:0]    pwdata,
    output logic [APB_W-1:0]    prdata,
    output logic                pready
);

    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W = RATE_W + CNT_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_BLEND = 3'd2;
    localparam logic [2:0] ST_CROSS = 3'd3;
    localparam logic [2:0] ST_RATE  = 3'd4;
    localparam logic [2:0] ST_MEAN  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [SAMPLE_W-1:0] nfl_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic [IVL_W-1:0]    min_ivl_reg;
    logic [IVL_W-1:0]    max_ivl_reg;
    logic                cfg_write;
    logic [1:0]          cfg_index;

    logic [2:0]          state_reg, state_next;
    logic [SAMPLE_W-1:0] sample_reg, sample_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [BASE_W-1:0]   baseline_reg, baseline_next;
    logic                seeded_reg, seeded_next;
    logic                rising_reg, rising_next;
    logic [TIME_W-1:0]   last_reg, last_next;
    logic [RATE_W-1:0]   latest_reg, latest_next;
    logic [RATE_W-1:0]   mean_reg, mean_next;
    logic                beat_reg, beat_next;
    logic                finger_reg, finger_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [BASE_W-1:0]        scaled;
    logic signed [DIFF_W-1:0] blend_diff;
    logic signed [DIFF_W-1:0] blend_prod;
    logic signed [DIFF_W-1:0] blend_sum;
    logic                     mac_start;
    logic                     mac_done;
    logic [TIME_W-1:0]        ibi;
    logic                     ibi_ok;
    logic                     div_start;
    logic                     div_done;
    logic [DIV_N_W-1:0]       div_dividend;
    logic [DIV_D_W-1:0]       div_divisor;
    logic [DIV_N_W-1:0]       div_quotient;
    logic [RATE_W-1:0]        rate_sat;
    logic                     ring_store;
    logic [SUM_W-1:0]         sum_new;
    logic [CNT_W-1:0]         fill_new;
    logic                     in_accept;
    logic                     out_free;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nfl_reg     <= NO_FINGER_RST;
            weight_reg  <= WEIGHT_RST;
            min_ivl_reg <= MIN_IVL_RST;
            max_ivl_reg <= MAX_IVL_RST;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_NO_FINGER: nfl_reg     <= pwdata[SAMPLE_W-1:0];
                REG_WEIGHT:    weight_reg  <= pwdata[WEIGHT_W-1:0];
                REG_MIN_IVL:   min_ivl_reg <= pwdata[IVL_W-1:0];
                REG_MAX_IVL:   max_ivl_reg <= pwdata[IVL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_NO_FINGER: prdata = APB_W'(nfl_reg);
            REG_WEIGHT:    prdata = APB_W'(weight_reg);
            REG_MIN_IVL:   prdata = APB_W'(min_ivl_reg);
            REG_MAX_IVL:   prdata = APB_W'(max_ivl_reg);
            default:       prdata = '0;
        endcase
    end

    // datapath units
    ppg_hbd_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mac_start),
        .diff    (blend_diff),
        .weight  (weight_reg),
        .done    (mac_done),
        .product (blend_prod)
    );

    ppg_hbd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    ppg_hbd_ring #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .CNT_W         (CNT_W),
        .SUM_W         (SUM_W)
    ) u_ring (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .store    (ring_store),
        .rate     (rate_sat),
        .sum_new  (sum_new),
        .fill_new (fill_new)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // blend: new = old + floor(w * (scaled - old) / 2^16)
    assign scaled     = {sample_reg, FRAC_W'(0)};
    assign blend_diff = $signed({1'b0, scaled}) - $signed({1'b0, baseline_reg});
    assign blend_sum  = $signed({1'b0, baseline_reg}) + blend_prod;

    assign ibi    = now_reg - last_reg;
    assign ibi_ok = (last_reg != '0) && (ibi > TIME_W'(min_ivl_reg))
                    && (ibi < TIME_W'(max_ivl_reg));

    assign rate_sat = (div_quotient[DIV_N_W-1:RATE_W] != '0) ? {RATE_W{1'b1}}
                                                              : div_quotient[RATE_W-1:0];

    always_comb begin
        div_dividend = (state_reg == ST_CROSS) ? RATE_NUMERATOR : DIV_N_W'(sum_new);
        div_divisor  = (state_reg == ST_CROSS) ? ibi[DIV_D_W-1:0] : DIV_D_W'(fill_new);
    end

    always_comb begin
        state_next    = state_reg;
        sample_next   = sample_reg;
        now_next      = now_reg;
        baseline_next = baseline_reg;
        seeded_next   = seeded_reg;
        rising_next   = rising_reg;
        last_next     = last_reg;
        latest_next   = latest_reg;
        mean_next     = mean_reg;
        beat_next     = beat_reg;
        finger_next   = finger_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        mac_start     = 1'b0;
        div_start     = 1'b0;
        ring_store    = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    sample_next = s_tdata[SAMPLE_W-1:0];
                    now_next    = s_tdata[SAMPLE_W+TIME_W-1:SAMPLE_W];
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                beat_next   = 1'b0;
                finger_next = (sample_reg >= nfl_reg);
                if (sample_reg < nfl_reg) begin
                    state_next = ST_DONE;
                end else if (!seeded_reg) begin
                    baseline_next = scaled;
                    seeded_next   = 1'b1;
                    state_next    = ST_CROSS;
                end else begin
                    mac_start  = 1'b1;
                    state_next = ST_BLEND;
                end
            end
            ST_BLEND: begin
                if (mac_done) begin
                    baseline_next = blend_sum[BASE_W-1:0];
                    state_next    = ST_CROSS;
                end
            end
            ST_CROSS: begin
                state_next = ST_DONE;
                if (scaled > baseline_reg) begin
                    if (!rising_reg) begin
                        rising_next = 1'b1;
                        last_next   = now_reg;
                        if (ibi_ok) begin
                            div_start  = 1'b1;
                            state_next = ST_RATE;
                        end
                    end
                end else begin
                    rising_next = 1'b0;
                end
            end
            ST_RATE: begin
                if (div_done) begin
                    latest_next = rate_sat;
                    ring_store  = 1'b1;
                    div_start   = 1'b1;
                    state_next  = ST_MEAN;
                end
            end
            ST_MEAN: begin
                if (div_done) begin
                    mean_next  = div_quotient[RATE_W-1:0];
                    beat_next  = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_DATA_W'({mean_reg, latest_reg, finger_reg, beat_reg});
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            seeded_reg   <= 1'b0;
            rising_reg   <= 1'b0;
            last_reg     <= '0;
            latest_reg   <= '0;
            mean_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            seeded_reg   <= seeded_next;
            rising_reg   <= rising_next;
            last_reg     <= last_next;
            latest_reg   <= latest_next;
            mean_reg     <= mean_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        sample_reg   <= sample_next;
        now_reg      <= now_next;
        baseline_reg <= baseline_next;
        beat_reg     <= beat_next;
        finger_reg   <= finger_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> state_reg == ST_CHECK)
        else $error("accepted sample did not start processing");

    a_seed_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        seeded_reg |=> seeded_reg)
        else $error("baseline seed flag cleared without reset");

    a_mean_sets_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MEAN && div_done) |=> (state_reg == ST_DONE && beat_reg))
        else $error("mean completion did not flag a beat");

    a_no_finger_no_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK && sample_reg < nfl_reg) |=> (!beat_reg && !finger_reg))
        else $error("no-finger sample flagged");

endmodule
